FILE: hdl/des_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// DES package
// Tables, permutation and round functions shared by the DES pipeline.
// ============================================================================
package des_pkg;

    localparam int unsigned ROUNDS = 16;
    localparam int unsigned BLOCK_W = 64;

    typedef logic [63:0] block_t;
    typedef logic [47:0] subkey_t;
    typedef logic [27:0] half28_t;

    typedef enum logic [0:0] {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic   valid;
        logic   cmd;
        logic [31:0] l;
        logic [31:0] r;
    } round_bus_t;

    localparam logic [7:0] IP_TAB [64] = '{
        8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
        8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
        8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,
        8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
        8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
        8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
        8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
        8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

    localparam logic [7:0] FP_TAB [64] = '{
        8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,
        8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
        8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,
        8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
        8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,
        8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
        8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
        8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

    localparam logic [7:0] E_TAB [48] = '{
        8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
        8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
        8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
        8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

    localparam logic [7:0] P_TAB [32] = '{
        8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,
        8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
        8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,
        8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

    localparam logic [7:0] PC1_TAB [56] = '{
        8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
        8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
        8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
        8'd60,8'd52,8'd44,8'd36,8'd63,8'd55,8'd47,8'd39,
        8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,
        8'd30,8'd22,8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,
        8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

    localparam logic [7:0] PC2_TAB [48] = '{
        8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,
        8'd15,8'd6,8'd21,8'd10,8'd23,8'd19,8'd12,8'd4,
        8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
        8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,
        8'd51,8'd45,8'd33,8'd48,8'd44,8'd49,8'd39,8'd56,
        8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

    localparam logic [1:0] ROT_TAB [16] = '{
        2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,
        2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

    localparam logic [3:0] S_TAB [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    function automatic block_t initial_perm(input block_t v);
        block_t r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - IP_TAB[i]];
        return r;
    endfunction

    function automatic block_t final_perm(input block_t v);
        block_t r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - FP_TAB[i]];
        return r;
    endfunction

    function automatic logic [55:0] pc1_perm(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - PC1_TAB[i]];
        return r;
    endfunction

    function automatic subkey_t pc2_perm(input logic [55:0] v);
        subkey_t r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - PC2_TAB[i]];
        return r;
    endfunction

    function automatic half28_t rot28(input half28_t h, input logic [1:0] n);
        half28_t r;
        case (n)
            2'd1:    r = {h[26:0], h[27]};
            2'd2:    r = {h[25:0], h[27:26]};
            default: r = h;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
        logic [47:0] e;
        logic [47:0] x;
        logic [5:0]  b;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) e[47-i] = r[32 - E_TAB[i]];
        x = e ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47 - 6*i -: 6];
            s[31 - 4*i -: 4] = S_TAB[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - P_TAB[i]];
        return p;
    endfunction

endpackage

FILE: hdl/des_keysched.sv
`timescale 1ns / 1ps
// ============================================================================
// DES key schedule
// Holds the key register and derives the sixteen round subkeys from it.
// ============================================================================
module des_keysched (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [63:0]             cfg_data,
    output des_pkg::subkey_t        subkeys [des_pkg::ROUNDS]
);

    logic [63:0]      key_reg;
    des_pkg::half28_t c_w [des_pkg::ROUNDS+1];
    des_pkg::half28_t d_w [des_pkg::ROUNDS+1];
    logic [55:0]      cd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            key_reg <= cfg_data;
        end
    end

    // subkeys settle long before use if the user writes config only while idle; the block does not enforce it
    always_comb
    begin
        cd0 = des_pkg::pc1_perm(key_reg);
        c_w[0] = cd0[55:28];
        d_w[0] = cd0[27:0];
        for (int i = 0; i < des_pkg::ROUNDS; i++)
        begin
            c_w[i+1] = des_pkg::rot28(c_w[i], des_pkg::ROT_TAB[i]);
            d_w[i+1] = des_pkg::rot28(d_w[i], des_pkg::ROT_TAB[i]);
            subkeys[i] = des_pkg::pc2_perm({c_w[i+1], d_w[i+1]});
        end
    end

endmodule

FILE: hdl/des_round.sv
`timescale 1ns / 1ps
// ============================================================================
// DES round stage
// One registered Feistel round; subkey picked by direction.
// ============================================================================
module des_round (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  des_pkg::subkey_t        key_enc,
    input  des_pkg::subkey_t        key_dec,
    input  des_pkg::round_bus_t     bus_in,
    output des_pkg::round_bus_t     bus_out
);

    des_pkg::round_bus_t bus_reg;
    des_pkg::round_bus_t bus_next;
    des_pkg::subkey_t    k;

    always_comb
    begin
        k = (bus_in.cmd == des_pkg::CMD_DECRYPT) ? key_dec : key_enc;
        bus_next.valid = bus_in.valid;
        bus_next.cmd   = bus_in.cmd;
        bus_next.l     = bus_in.r;
        bus_next.r     = bus_in.l ^ des_pkg::feistel(bus_in.r, k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (advance)
        begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

FILE: hdl/des_block_cipher_top.sv
`timescale 1ns / 1ps
// ============================================================================
// DES block cipher top
// Sixteen-stage round pipeline with IP on entry and FP on the output register.
// ============================================================================
//  channel   direction  handshake        payload
//  in        input      valid / stall    cmd, data_in
//  out       output     valid / stall    data_out
//  cfg       input      valid / ready    cfg_data (key)
//
//  One transaction per cycle while not stalled; path: 16 round registers + output.
//  The pipeline moves as a whole; out_stall freezes it only when the output
//  register holds a transaction, so an empty output never holds it back.
//  Reset clears all valid bits and sets the key to zero.
//  cfg_ready is always high.
module des_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [63:0] data_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    des_pkg::subkey_t    subkeys [des_pkg::ROUNDS];
    des_pkg::round_bus_t stage [des_pkg::ROUNDS+1];
    des_pkg::block_t     ip_w;
    logic                advance;
    logic                out_valid_reg;
    logic [63:0]         data_out_reg;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    des_keysched u_keysched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .subkeys   (subkeys)
    );

    always_comb
    begin
        ip_w = des_pkg::initial_perm(data_in);
        stage[0].valid = in_valid;
        stage[0].cmd   = cmd;
        stage[0].l     = ip_w[63:32];
        stage[0].r     = ip_w[31:0];
    end

    for (genvar g = 0; g < des_pkg::ROUNDS; g++)
    begin : g_round
        des_round u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .key_enc (subkeys[g]),
            .key_dec (subkeys[des_pkg::ROUNDS-1-g]),
            .bus_in  (stage[g]),
            .bus_out (stage[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage[des_pkg::ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_out_reg <= des_pkg::final_perm(
                {stage[des_pkg::ROUNDS].r, stage[des_pkg::ROUNDS].l});
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

    property p_hold_data;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(data_out) && out_valid;
    endproperty
    a_hold_data: assert property (p_hold_data) else $error("output changed while stalled");

    property p_no_stall_when_empty;
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall;
    endproperty
    a_no_stall_when_empty: assert property (p_no_stall_when_empty)
        else $error("input stalled with empty output");

    property p_last_stage_moves;
        @(posedge clk) disable iff (!rst_n)
        advance && stage[des_pkg::ROUNDS].valid |=> out_valid;
    endproperty
    a_last_stage_moves: assert property (p_last_stage_moves)
        else $error("result lost at output register");

endmodule
